### rtl/accel_tilt_angles_macros.svh
// assertion helpers for the tilt angle block, clocked on clk_i, off in reset
`ifndef ACCEL_TILT_ANGLES_MACROS_SVH
`define ACCEL_TILT_ANGLES_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define ATA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold after the antecedent, delayed by the n argument
`define ATA_ASSERT_LATER(lbl, ante, n, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> ##(n) (cons)) \
    else $error(msg);

`endif

### rtl/ata_pkg.sv
package ata_pkg;

  localparam int SampleBitsDef   = 16;
  localparam int CordicStagesDef = 16;
  localparam int AtanLen         = 24;
  localparam int ZWidth          = 24;
  localparam int FracBits        = 16;
  localparam int NumShift        = 8;
  localparam int MagShift        = 16;
  localparam int LimitDeg        = 90;
  localparam int DegWidth        = 8;

  // atan(2^-i) in degrees, 16 fractional bits, rounded
  function automatic logic signed [ZWidth-1:0] atan_deg(input int unsigned idx);
    logic signed [ZWidth-1:0] t;
    case (idx)
      0:       t = 24'sd2949120;
      1:       t = 24'sd1740967;
      2:       t = 24'sd919879;
      3:       t = 24'sd466945;
      4:       t = 24'sd234379;
      5:       t = 24'sd117304;
      6:       t = 24'sd58666;
      7:       t = 24'sd29335;
      8:       t = 24'sd14668;
      9:       t = 24'sd7334;
      10:      t = 24'sd3667;
      11:      t = 24'sd1833;
      12:      t = 24'sd917;
      13:      t = 24'sd458;
      14:      t = 24'sd229;
      15:      t = 24'sd115;
      16:      t = 24'sd57;
      17:      t = 24'sd29;
      18:      t = 24'sd14;
      19:      t = 24'sd7;
      20:      t = 24'sd4;
      21:      t = 24'sd2;
      22:      t = 24'sd1;
      default: t = '0;
    endcase
    return t;
  endfunction

  // whole degrees, truncated toward zero, limited to +-90
  function automatic logic signed [DegWidth-1:0] deg_of(input logic signed [ZWidth-1:0] z);
    logic [ZWidth-1:0]          mag;
    logic [ZWidth-FracBits-1:0] q;
    logic [DegWidth-1:0]        d;
    mag = z[ZWidth-1] ? ZWidth'(-z) : ZWidth'(z);
    q   = mag[ZWidth-1:FracBits];
    d   = (DegWidth'(q) > DegWidth'(LimitDeg)) ? DegWidth'(LimitDeg) : DegWidth'(q);
    return z[ZWidth-1] ? $signed(-d) : $signed(d);
  endfunction

endpackage

### rtl/ata_sqrt_cell.sv
module ata_sqrt_cell #(
  parameter int RootWidth = 24,
  parameter int PayWidth  = 16
) (
  input  logic                   clk_i,
  input  logic [2*RootWidth-1:0] v_i,
  input  logic [RootWidth+1:0]   rem_i,
  input  logic [RootWidth-1:0]   root_i,
  input  logic [PayWidth-1:0]    pay_i,
  output logic [2*RootWidth-1:0] v_o,
  output logic [RootWidth+1:0]   rem_o,
  output logic [RootWidth-1:0]   root_o,
  output logic [PayWidth-1:0]    pay_o
);

  logic [2*RootWidth-1:0] v_q;
  logic [RootWidth+1:0]   rem_q, rem_d, rem_sh, trial;
  logic [RootWidth-1:0]   root_q, root_d;
  logic [PayWidth-1:0]    pay_q;
  logic                   ge;

  // bring down the next two radicand bits and try the next root bit
  always_comb begin
    rem_sh = {rem_i[RootWidth-1:0], v_i[2*RootWidth-1 -: 2]};
    trial  = {root_i, 2'b01};
    ge     = (rem_sh >= trial);
    rem_d  = ge ? (rem_sh - trial) : rem_sh;
    root_d = {root_i[RootWidth-2:0], ge};
  end

  always_ff @(posedge clk_i) begin
    v_q    <= {v_i[2*RootWidth-3:0], 2'b00};
    rem_q  <= rem_d;
    root_q <= root_d;
    pay_q  <= pay_i;
  end

  assign v_o    = v_q;
  assign rem_o  = rem_q;
  assign root_o = root_q;
  assign pay_o  = pay_q;

endmodule

### rtl/ata_cordic_cell.sv
module ata_cordic_cell
  import ata_pkg::*;
#(
  parameter int Idx      = 0,
  parameter int CWidth   = 26,
  parameter int PayWidth = 3
) (
  input  logic                     clk_i,
  input  logic signed [CWidth-1:0] x_i,
  input  logic signed [CWidth-1:0] y_i,
  input  logic signed [ZWidth-1:0] z_i,
  input  logic [PayWidth-1:0]      pay_i,
  output logic signed [CWidth-1:0] x_o,
  output logic signed [CWidth-1:0] y_o,
  output logic signed [ZWidth-1:0] z_o,
  output logic [PayWidth-1:0]      pay_o
);

  localparam logic signed [ZWidth-1:0] Step = atan_deg(Idx);

  logic signed [CWidth-1:0] x_q, x_d, y_q, y_d, dx, dy;
  logic signed [ZWidth-1:0] z_q, z_d;
  logic [PayWidth-1:0]      pay_q;

  always_comb begin
    dx = y_i >>> Idx;
    dy = x_i >>> Idx;
    // rotate toward the x axis
    if (!y_i[CWidth-1]) begin
      x_d = x_i + dx;
      y_d = y_i - dy;
      z_d = z_i + Step;
    end else begin
      x_d = x_i - dx;
      y_d = y_i + dy;
      z_d = z_i - Step;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    y_q   <= y_d;
    z_q   <= z_d;
    pay_q <= pay_i;
  end

  assign x_o   = x_q;
  assign y_o   = y_q;
  assign z_o   = z_q;
  assign pay_o = pay_q;

endmodule

### rtl/accel_tilt_angles.sv
// Tilt angles from one accelerometer sample: pitch = atan2(x, |(y,z)|) and
// roll = atan2(y, |(x,z)|) in whole degrees, truncated toward zero, -90..90.
// A sample is taken on any clock with start_i high (busy_o stays low), so one
// sample per clock is sustained. Each result appears on pitch_deg_o and
// roll_deg_o for one clock with valid_o high, after it has passed the
// squares register, a row of SAMPLE_BITS + 8 square root cells (one root
// bit each), a row of CORDIC_STAGES rotation cells (at most 24) and one
// output register. The receiver cannot stall, so results must be taken as
// they appear.
`include "accel_tilt_angles_macros.svh"

module accel_tilt_angles
  import ata_pkg::*;
#(
  parameter int SAMPLE_BITS   = SampleBitsDef,
  parameter int CORDIC_STAGES = CordicStagesDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic signed [SAMPLE_BITS-1:0] accel_x_i,
  input  logic signed [SAMPLE_BITS-1:0] accel_y_i,
  input  logic signed [SAMPLE_BITS-1:0] accel_z_i,
  output logic                          valid_o,
  output logic signed [DegWidth-1:0]    pitch_deg_o,
  output logic signed [DegWidth-1:0]    roll_deg_o
);

  localparam int SB  = SAMPLE_BITS;
  localparam int CS  = (CORDIC_STAGES > AtanLen) ? AtanLen : CORDIC_STAGES;
  localparam int RW  = SB + NumShift;
  localparam int VW  = 2 * RW;
  localparam int MW  = RW + 2;
  localparam int CW  = SB + 10;
  localparam int PW  = 3;
  localparam int LAT = RW + CS + 2;

  logic accept;
  logic [LAT-1:0] vld_q;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[LAT-2:0], accept};
    end
  end

  // squares
  logic [2*SB-1:0]        xx_q, yy_q, zz_q, psum, rsum;
  logic signed [SB-1:0]   nx_q, ny_q;
  logic signed [2*SB-1:0] ax, ay, az;

  assign ax = accel_x_i;
  assign ay = accel_y_i;
  assign az = accel_z_i;

  always_ff @(posedge clk_i) begin
    xx_q <= $unsigned(ax * ax);
    yy_q <= $unsigned(ay * ay);
    zz_q <= $unsigned(az * az);
    nx_q <= accel_x_i;
    ny_q <= accel_y_i;
  end

  assign psum = yy_q + zz_q;
  assign rsum = xx_q + zz_q;

  // square root rows, pitch and roll side by side
  logic [VW-1:0] pv   [RW+1];
  logic [VW-1:0] rv   [RW+1];
  logic [MW-1:0] prem [RW+1];
  logic [MW-1:0] rrem [RW+1];
  logic [RW-1:0] prt  [RW+1];
  logic [RW-1:0] rrt  [RW+1];
  logic [SB-1:0] pnum [RW+1];
  logic [SB-1:0] rnum [RW+1];

  assign pv[0]   = {psum, {MagShift{1'b0}}};
  assign rv[0]   = {rsum, {MagShift{1'b0}}};
  assign prem[0] = '0;
  assign rrem[0] = '0;
  assign prt[0]  = '0;
  assign rrt[0]  = '0;
  assign pnum[0] = nx_q;
  assign rnum[0] = ny_q;

  for (genvar k = 0; k < RW; k++) begin : g_sqrt
    ata_sqrt_cell #(.RootWidth(RW), .PayWidth(SB)) u_psqrt (
      .clk_i, .v_i(pv[k]), .rem_i(prem[k]), .root_i(prt[k]), .pay_i(pnum[k]),
      .v_o(pv[k+1]), .rem_o(prem[k+1]), .root_o(prt[k+1]), .pay_o(pnum[k+1])
    );
    ata_sqrt_cell #(.RootWidth(RW), .PayWidth(SB)) u_rsqrt (
      .clk_i, .v_i(rv[k]), .rem_i(rrem[k]), .root_i(rrt[k]), .pay_i(rnum[k]),
      .v_o(rv[k+1]), .rem_o(rrem[k+1]), .root_o(rrt[k+1]), .pay_o(rnum[k+1])
    );
  end

  // rotation rows; side bits carry zero magnitude, nonzero and sign of numerator
  logic signed [CW-1:0]     px [CS+1];
  logic signed [CW-1:0]     py [CS+1];
  logic signed [ZWidth-1:0] pz [CS+1];
  logic [PW-1:0]            ps [CS+1];
  logic signed [CW-1:0]     rx [CS+1];
  logic signed [CW-1:0]     ry [CS+1];
  logic signed [ZWidth-1:0] rz [CS+1];
  logic [PW-1:0]            rs [CS+1];

  assign px[0] = $signed({{(CW-RW){1'b0}}, prt[RW]});
  assign rx[0] = $signed({{(CW-RW){1'b0}}, rrt[RW]});
  assign py[0] = $signed({{(CW-RW){pnum[RW][SB-1]}}, pnum[RW], {NumShift{1'b0}}});
  assign ry[0] = $signed({{(CW-RW){rnum[RW][SB-1]}}, rnum[RW], {NumShift{1'b0}}});
  assign pz[0] = '0;
  assign rz[0] = '0;
  assign ps[0] = {prt[RW] == '0, pnum[RW] != '0, pnum[RW][SB-1]};
  assign rs[0] = {rrt[RW] == '0, rnum[RW] != '0, rnum[RW][SB-1]};

  for (genvar j = 0; j < CS; j++) begin : g_cordic
    ata_cordic_cell #(.Idx(j), .CWidth(CW), .PayWidth(PW)) u_pcell (
      .clk_i, .x_i(px[j]), .y_i(py[j]), .z_i(pz[j]), .pay_i(ps[j]),
      .x_o(px[j+1]), .y_o(py[j+1]), .z_o(pz[j+1]), .pay_o(ps[j+1])
    );
    ata_cordic_cell #(.Idx(j), .CWidth(CW), .PayWidth(PW)) u_rcell (
      .clk_i, .x_i(rx[j]), .y_i(ry[j]), .z_i(rz[j]), .pay_i(rs[j]),
      .x_o(rx[j+1]), .y_o(ry[j+1]), .z_o(rz[j+1]), .pay_o(rs[j+1])
    );
  end

  // output register
  logic signed [DegWidth-1:0] pitch_q, pitch_d, roll_q, roll_d;
  logic signed [DegWidth-1:0] pos_lim, neg_lim;

  assign pos_lim = DegWidth'(LimitDeg);
  assign neg_lim = DegWidth'(-LimitDeg);

  always_comb begin
    if (ps[CS][2]) begin
      pitch_d = ps[CS][1] ? (ps[CS][0] ? neg_lim : pos_lim) : '0;
    end else begin
      pitch_d = deg_of(pz[CS]);
    end
    if (rs[CS][2]) begin
      roll_d = rs[CS][1] ? (rs[CS][0] ? neg_lim : pos_lim) : '0;
    end else begin
      roll_d = deg_of(rz[CS]);
    end
  end

  always_ff @(posedge clk_i) begin
    pitch_q <= pitch_d;
    roll_q  <= roll_d;
  end

  assign valid_o     = vld_q[LAT-1];
  assign pitch_deg_o = pitch_q;
  assign roll_deg_o  = roll_q;

  logic zero_in, pitch_ok, roll_ok, zero_out;

  assign zero_in  = accept && (accel_x_i == '0) && (accel_y_i == '0) && (accel_z_i == '0);
  assign pitch_ok = (pitch_deg_o <= pos_lim) && (pitch_deg_o >= neg_lim);
  assign roll_ok  = (roll_deg_o <= pos_lim) && (roll_deg_o >= neg_lim);
  assign zero_out = (pitch_deg_o == '0) && (roll_deg_o == '0);

  `ATA_ASSERT_LATER(a_item_out, accept, LAT, valid_o, "accepted item gave no result")
  `ATA_ASSERT_NOW(a_pitch_range, valid_o, pitch_ok, "pitch out of range")
  `ATA_ASSERT_NOW(a_roll_range, valid_o, roll_ok, "roll out of range")
  `ATA_ASSERT_LATER(a_zero_in, zero_in, LAT, zero_out, "zero sample gave nonzero angle")

endmodule
